>>> rtl/core/sjfq_pkg.sv
// Shared constants for the shortest-job-first queue and its checker.
package sjfq_pkg;

  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned TagBitsDef    = 16;

  localparam int unsigned LenW   = 32;
  localparam int unsigned TagW   = 16;
  localparam int unsigned CountW = 5;
  localparam int unsigned StatW  = 2;

  localparam logic [StatW-1:0] ST_OK       = 2'd0;
  localparam logic [StatW-1:0] ST_FULL     = 2'd1;
  localparam logic [StatW-1:0] ST_DISABLED = 2'd2;
  localparam logic [StatW-1:0] ST_EMPTY    = 2'd3;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_TAKE   = 1'b1;

endpackage

>>> rtl/core/shortest_job_first_queue.sv
// Shortest-job-first queue: sorted job store walked by one shared comparator.
// An insert walks the store from tail to head, one entry a cycle, until its slot is found;
// a take reads the head, then shifts one entry a cycle; refused or empty items go to the result.
// Throughput: one transaction at a time; the next is taken the cycle after the result is staged.
// The store memory has one write and one registered read port, which sets the walk rate.
// Reset clears the count, the result valid flag and the state; accept_enable resets to 1.
module shortest_job_first_queue #(
  parameter int unsigned QUEUE_DEPTH = sjfq_pkg::QueueDepthDef,
  parameter int unsigned TAG_BITS    = sjfq_pkg::TagBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          func_i,
  input  logic [sjfq_pkg::LenW-1:0]     job_length_i,
  input  logic [sjfq_pkg::TagW-1:0]     job_tag_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sjfq_pkg::StatW-1:0]    status_o,
  output logic [sjfq_pkg::LenW-1:0]     out_length_o,
  output logic [sjfq_pkg::TagW-1:0]     out_tag_o,
  output logic [sjfq_pkg::CountW-1:0]   queued_count_o
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW = (TAG_BITS < sjfq_pkg::TagW) ? TAG_BITS : sjfq_pkg::TagW;
  localparam int unsigned LW = sjfq_pkg::LenW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_TKH  = 3'd2;
  localparam logic [2:0] S_TK   = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [LW-1:0] mem_len [QUEUE_DEPTH];
  logic [SW-1:0] mem_tag [QUEUE_DEPTH];

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          acc_en_q;
  logic [LW-1:0] len_q, len_d;
  logic [SW-1:0] tag_q, tag_d;
  logic [LW-1:0] rd_len_q;
  logic [SW-1:0] rd_tag_q;

  logic [sjfq_pkg::StatW-1:0] res_st_q, res_st_d;
  logic [LW-1:0]              res_len_q, res_len_d;
  logic [SW-1:0]              res_tag_q, res_tag_d;

  logic                       out_valid_q, out_valid_d;
  logic [sjfq_pkg::StatW-1:0] out_st_q;
  logic [LW-1:0]              out_len_q;
  logic [SW-1:0]              out_tag_q;
  logic [CW-1:0]              out_cnt_q;

  logic          in_acc;
  logic          load;
  logic [AW-1:0] rd_addr;
  logic          we;
  logic [AW-1:0] wa;
  logic [LW-1:0] wlen;
  logic [SW-1:0] wtag;
  logic          entry_lt;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign load       = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);
  // the one shared compare
  assign entry_lt   = (rd_len_q < len_q);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    len_d     = len_q;
    tag_d     = tag_q;
    res_st_d  = res_st_q;
    res_len_d = res_len_q;
    res_tag_d = res_tag_q;
    rd_addr   = '0;
    we        = 1'b0;
    wa        = AW'(idx_q);
    wlen      = rd_len_q;
    wtag      = rd_tag_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          len_d     = job_length_i;
          tag_d     = job_tag_i[SW-1:0];
          res_len_d = '0;
          res_tag_d = '0;
          res_st_d  = sjfq_pkg::ST_OK;
          if (func_i == sjfq_pkg::FUNC_INSERT) begin
            rd_addr = AW'(count_q - CW'(1));
            idx_d   = count_q;
            if (!acc_en_q) begin
              res_st_d = sjfq_pkg::ST_DISABLED;
              state_d  = S_FIN;
            end else if (count_q == CW'(QUEUE_DEPTH)) begin
              res_st_d = sjfq_pkg::ST_FULL;
              state_d  = S_FIN;
            end else begin
              state_d = S_INS;
            end
          end else begin
            rd_addr = '0;
            if (count_q == '0) begin
              res_st_d = sjfq_pkg::ST_EMPTY;
              state_d  = S_FIN;
            end else begin
              state_d = S_TKH;
            end
          end
        end
      end
      S_INS: begin
        we      = 1'b1;
        rd_addr = AW'(idx_q - CW'(2));
        if (idx_q == '0 || entry_lt) begin
          wlen    = len_q;
          wtag    = tag_q;
          count_d = count_q + CW'(1);
          state_d = S_FIN;
        end else begin
          // shift the equal or larger entry one slot toward the tail
          idx_d = idx_q - CW'(1);
        end
      end
      S_TKH: begin
        res_len_d = rd_len_q;
        res_tag_d = rd_tag_q;
        rd_addr   = AW'(1);
        idx_d     = CW'(1);
        if (count_q == CW'(1)) begin
          count_d = '0;
          state_d = S_FIN;
        end else begin
          state_d = S_TK;
        end
      end
      S_TK: begin
        we      = 1'b1;
        wa      = AW'(idx_q - CW'(1));
        rd_addr = AW'(idx_q + CW'(1));
        if (idx_q == count_q - CW'(1)) begin
          count_d = count_q - CW'(1);
          state_d = S_FIN;
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end
      S_FIN: begin
        if (load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_len[wa] <= wlen;
      mem_tag[wa] <= wtag;
    end
    rd_len_q <= mem_len[rd_addr];
    rd_tag_q <= mem_tag[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      acc_en_q    <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        acc_en_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    len_q     <= len_d;
    tag_q     <= tag_d;
    res_st_q  <= res_st_d;
    res_len_q <= res_len_d;
    res_tag_q <= res_tag_d;
    if (load) begin
      out_st_q  <= res_st_q;
      out_len_q <= res_len_q;
      out_tag_q <= res_tag_q;
      out_cnt_q <= count_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_st_q;
  assign out_length_o   = out_len_q;
  assign out_tag_o      = sjfq_pkg::TagW'(out_tag_q);
  assign queued_count_o = sjfq_pkg::CountW'(out_cnt_q);

endmodule

>>> rtl/core/sjfq_checker.sv
// Port-level checker for the shortest-job-first queue, bound to the top level.
module sjfq_checker #(
  parameter int unsigned QUEUE_DEPTH = sjfq_pkg::QueueDepthDef
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [sjfq_pkg::StatW-1:0]  status_o,
  input logic [sjfq_pkg::LenW-1:0]   out_length_o,
  input logic [sjfq_pkg::TagW-1:0]   out_tag_o,
  input logic [sjfq_pkg::CountW-1:0] queued_count_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(out_length_o) && $stable(out_tag_o) && $stable(queued_count_o))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again before the transaction finished");

  a_no_job_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != sjfq_pkg::ST_OK |-> out_length_o == '0 && out_tag_o == '0)
    else $error("failed transaction returned a job");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == sjfq_pkg::ST_FULL
      |-> queued_count_o == sjfq_pkg::CountW'(QUEUE_DEPTH))
    else $error("full status with store not full");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == sjfq_pkg::ST_EMPTY |-> queued_count_o == '0)
    else $error("empty status with jobs stored");

endmodule

bind shortest_job_first_queue sjfq_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_sjfq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .status_o       (status_o),
  .out_length_o   (out_length_o),
  .out_tag_o      (out_tag_o),
  .queued_count_o (queued_count_o)
);

>>> tb/shortest_job_first_queue_checker.sv
// Checker for the shortest-job-first queue: watches both channels, predicts and compares.
module shortest_job_first_queue_checker
  import sjfq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  parameter int unsigned TAG_BITS    = TagBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic              func_i,
  input  logic [LenW-1:0]   job_length_i,
  input  logic [TagW-1:0]   job_tag_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [StatW-1:0]  status_i,
  input  logic [LenW-1:0]   out_length_i,
  input  logic [TagW-1:0]   out_tag_i,
  input  logic [CountW-1:0] queued_count_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o,
  output int unsigned       results_o,
  output int unsigned       full_hits_o,
  output int unsigned       refused_hits_o,
  output int unsigned       empty_hits_o
);

  typedef struct packed {
    logic [StatW-1:0]  status;
    logic [LenW-1:0]   length;
    logic [TagW-1:0]   tag;
    logic [CountW-1:0] count;
  } job_result_t;

  localparam logic [TagW-1:0] TagKeep =
    (TAG_BITS >= TagW) ? {TagW{1'b1}} : TagW'((64'd1 << TAG_BITS) - 64'd1);

  logic [LenW-1:0] slot_length [QUEUE_DEPTH];
  logic [TagW-1:0] slot_tag    [QUEUE_DEPTH];
  int unsigned     jobs_held;
  logic            accepting;
  job_result_t     results_due [$];

  // Apply one transaction to the sorted store and return the status it earns.
  function automatic job_result_t serve_job(input logic func, input logic [LenW-1:0] len,
                                            input logic [TagW-1:0] tag);
    job_result_t res;
    int unsigned pos;
    res = '0;
    if (func == FUNC_INSERT) begin
      if (!accepting) begin
        res.status = ST_DISABLED;
      end else if (jobs_held >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        // new job goes ahead of every equal or longer one
        pos = 0;
        while (pos < jobs_held && slot_length[pos] < len) pos++;
        for (int unsigned i = jobs_held; i > pos; i--) begin
          slot_length[i] = slot_length[i-1];
          slot_tag[i]    = slot_tag[i-1];
        end
        slot_length[pos] = len;
        slot_tag[pos]    = tag & TagKeep;
        jobs_held++;
        res.status = ST_OK;
      end
    end else if (jobs_held == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.length = slot_length[0];
      res.tag    = slot_tag[0];
      for (int unsigned i = 1; i < jobs_held; i++) begin
        slot_length[i-1] = slot_length[i];
        slot_tag[i-1]    = slot_tag[i];
      end
      jobs_held--;
      res.status = ST_OK;
    end
    res.count = CountW'(jobs_held);
    return res;
  endfunction

  task automatic flag_result(input string why, input job_result_t want, input job_result_t got);
    if (fail_count_o < 10) begin
      $display("result %0d %s: expected st=%0d len=%h tag=%h cnt=%0d", results_o, why,
               want.status, want.length, want.tag, want.count);
      $display("  got st=%0d len=%h tag=%h cnt=%0d", got.status, got.length, got.tag,
               got.count);
    end
    fail_count_o++;
  endtask

  always @(posedge clk_i) begin
    job_result_t seen;
    job_result_t due;
    if (!rst_ni) begin
      jobs_held      = 0;
      accepting      = 1'b1;
      results_due.delete();
      fail_count_o   = 0;
      pending_o      = 0;
      results_o      = 0;
      full_hits_o    = 0;
      refused_hits_o = 0;
      empty_hits_o   = 0;
    end else begin
      // results leave before the new transaction is predicted
      if (out_valid_i && !out_stall_i) begin
        seen = {status_i, out_length_i, out_tag_i, queued_count_i};
        results_o++;
        if (results_due.size() == 0) begin
          flag_result("with nothing pending", '0, seen);
        end else begin
          due = results_due.pop_front();
          if (seen !== due) flag_result("mismatch", due, seen);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        due = serve_job(func_i, job_length_i, job_tag_i);
        results_due.push_back(due);
        case (due.status)
          ST_FULL:     full_hits_o++;
          ST_DISABLED: refused_hits_o++;
          ST_EMPTY:    empty_hits_o++;
          default:     ;
        endcase
      end
      if (cfg_we_i) accepting = cfg_wdata_i;
      pending_o = results_due.size();
    end
  end

endmodule

>>> tb/shortest_job_first_queue_tb.sv
// Testbench top for the shortest-job-first queue: clock, reset, stimulus and verdict.
module shortest_job_first_queue_tb;
  import sjfq_pkg::*;

  localparam int unsigned CycleLimit    = 1_000_000;
  localparam int unsigned PhaseCount    = 10;
  localparam int unsigned ItemsPerPhase = 130;
  localparam int unsigned HoldPhase     = 3;
  localparam int unsigned HoldCycles    = 300;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic              cfg_wdata_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              func_i;
  logic [LenW-1:0]   job_length_i;
  logic [TagW-1:0]   job_tag_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [StatW-1:0]  status_o;
  logic [LenW-1:0]   out_length_o;
  logic [TagW-1:0]   out_tag_o;
  logic [CountW-1:0] queued_count_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results;
  int unsigned full_hits;
  int unsigned refused_hits;
  int unsigned empty_hits;

  logic        tx_gap_on;
  logic        rx_stall_on;
  logic        hold_go;
  logic        hold_done;
  int unsigned jobs_sent;
  int unsigned settings_written;

  shortest_job_first_queue dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .job_length_i   (job_length_i),
    .job_tag_i      (job_tag_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .out_length_o   (out_length_o),
    .out_tag_o      (out_tag_o),
    .queued_count_o (queued_count_o)
  );

  shortest_job_first_queue_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .func_i         (func_i),
    .job_length_i   (job_length_i),
    .job_tag_i      (job_tag_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_i       (status_o),
    .out_length_i   (out_length_o),
    .out_tag_i      (out_tag_o),
    .queued_count_i (queued_count_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .results_o      (results),
    .full_hits_o    (full_hits),
    .refused_hits_o (refused_hits),
    .empty_hits_o   (empty_hits)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Favor small lengths so that ties are common, with the extremes mixed in.
  function automatic logic [LenW-1:0] pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return LenW'($urandom_range(0, 7));
    if (r < 48) return '0;
    if (r < 56) return '1;
    if (r < 64) return {{(LenW-3){1'b1}}, 3'($urandom_range(0, 7))};
    return $urandom;
  endfunction

  task automatic send_job(input logic func, input logic [LenW-1:0] len,
                          input logic [TagW-1:0] tag);
    int unsigned gap;
    gap = tx_gap_on ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    func_i       <= func;
    job_length_i <= len;
    job_tag_i    <= tag;
    do @(posedge clk_i); while (in_stall_o);
    jobs_sent++;
  endtask

  // Drop valid and wait until every outstanding transaction has its result.
  task automatic settle_queue();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_accept(input logic enable);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= enable;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    settings_written++;
  endtask

  // Receiver: random stall runs, plus one long hold-off on request.
  initial begin
    int unsigned run_left;
    logic        stall_next;
    out_stall_i = 1'b0;
    hold_done   = 1'b0;
    run_left    = 0;
    stall_next  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_go && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles - 1) @(negedge clk_i);
        hold_done  = 1'b1;
        run_left   = 0;
        stall_next = 1'b0;
      end else begin
        if (!rx_stall_on) begin
          stall_next = 1'b0;
          run_left   = 0;
        end else if (run_left == 0) begin
          if ($urandom_range(0, 99) < 35) begin
            stall_next = 1'b1;
            run_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 2);
          end else begin
            stall_next = 1'b0;
            run_left   = $urandom_range(0, 5);
          end
        end else begin
          run_left--;
        end
        out_stall_i <= stall_next;
      end
    end
  end

  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still pending", cycle_count, pending);
    $display("** shortest_job_first_queue: FAILED **");
    $finish;
  end

  initial begin
    logic        accept;
    int unsigned take_pct;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = 1'b0;
    in_valid_i       = 1'b0;
    func_i           = FUNC_INSERT;
    job_length_i     = '0;
    job_tag_i        = '0;
    tx_gap_on        = 1'b0;
    rx_stall_on      = 1'b1;
    hold_go          = 1'b0;
    jobs_sent        = 0;
    settings_written = 0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty take, extremes, a tie, disabled inserts and takes, full store
    send_job(FUNC_TAKE, '0, '0);
    send_job(FUNC_INSERT, '1, '1);
    send_job(FUNC_INSERT, '0, '0);
    send_job(FUNC_INSERT, 32'd7, 16'h0001);
    send_job(FUNC_INSERT, 32'd7, 16'h0002);
    send_job(FUNC_TAKE, '0, '0);
    send_job(FUNC_TAKE, '0, '0);
    settle_queue();
    write_accept(1'b0);
    send_job(FUNC_INSERT, 32'd3, 16'hA5A5);
    send_job(FUNC_TAKE, '0, '0);
    settle_queue();
    write_accept(1'b1);
    for (int i = 0; i < 15; i++) begin
      send_job(FUNC_INSERT, (i == 0) ? '1 : ((i % 4 == 0) ? '0 : LenW'($urandom_range(1, 3))),
               TagW'(i * 16'h1111));
    end
    send_job(FUNC_INSERT, 32'd1, 16'h5A5A);
    settle_queue();
    write_accept(1'b0);
    send_job(FUNC_INSERT, 32'd1, 16'h5A5A);

    // random phases: fill-heavy, drain-heavy and balanced mixes under several settings
    for (int p = 0; p < PhaseCount; p++) begin
      settle_queue();
      if (p == 2 || p == 6) accept = 1'b0;
      else if (p == PhaseCount - 1) accept = 1'($urandom_range(0, 1));
      else accept = 1'b1;
      write_accept(accept);
      tx_gap_on   = (p % 4 != 1) && (p != 4);
      rx_stall_on = (p % 4 != 2) && (p != 4);
      case (p % 3)
        0:       take_pct = 25;
        1:       take_pct = 75;
        default: take_pct = 50;
      endcase
      // hold the output while the sender keeps pushing
      if (p == HoldPhase) hold_go = 1'b1;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        send_job(($urandom_range(0, 99) < take_pct) ? FUNC_TAKE : FUNC_INSERT,
                 pick_length(), TagW'($urandom));
      end
    end

    settle_queue();
    repeat (40) @(posedge clk_i);
    $display("sent %0d jobs under %0d enable settings, checked %0d results", jobs_sent,
             settings_written, results);
    $display("store full %0d, refused while disabled %0d, empty takes %0d", full_hits,
             refused_hits, empty_hits);
    if (fail_count == 0 && pending == 0) begin
      $display("** shortest_job_first_queue: PASSED **");
    end else begin
      $display("%0d failures, %0d results never arrived", fail_count, pending);
      $display("** shortest_job_first_queue: FAILED **");
    end
    $finish;
  end

endmodule
